FILE: hdl/arpc_pkg.sv
`default_nettype none
package arpc_pkg;

	localparam int ENTRIES_DEF = 16;

	localparam int OP_W   = 3;
	localparam int IP_W   = 32;
	localparam int MAC_W  = 48;
	localparam int AGE_W  = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 48;

	localparam logic [AGE_W-1:0] MAX_AGE_RST = 8'd120;

	localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
	localparam logic [OP_W-1:0] OP_IP     = 3'd1;
	localparam logic [OP_W-1:0] OP_REQ    = 3'd2;
	localparam logic [OP_W-1:0] OP_REPLY  = 3'd3;
	localparam logic [OP_W-1:0] OP_LOOKUP = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASK     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MAC = 2'd3;

	typedef struct packed {
		logic load;
		logic scan;
		logic write;
		logic out_load;
	} arpc_cmd_t;

	typedef struct packed {
		logic need_scan;
		logic need_write;
		logic scan_done;
	} arpc_status_t;

endpackage
`default_nettype wire

FILE: hdl/arpc_ctrl.sv
`default_nettype none
module arpc_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire                   out_stall,
	input  arpc_pkg::arpc_status_t st,
	output arpc_pkg::arpc_cmd_t    cmd
);
	import arpc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_WRITE  = 4'b0100,
		S_RESULT = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = st.need_scan;
				if (!st.need_scan)
					state_d = S_RESULT;
				else if (st.scan_done)
					state_d = st.need_write ? S_WRITE : S_RESULT;
			end
			S_WRITE: begin
				cmd.write = 1'b1;
				state_d   = S_RESULT;
			end
			S_RESULT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

FILE: hdl/arpc_dp.sv
`default_nettype none
module arpc_dp #(
	parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  arpc_pkg::arpc_cmd_t                 cmd,
	output arpc_pkg::arpc_status_t              st,
	input  wire                                 cfg_we,
	input  wire  [arpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [arpc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire  [arpc_pkg::OP_W-1:0]           op,
	input  wire  [arpc_pkg::IP_W-1:0]           sender_ip,
	input  wire  [arpc_pkg::MAC_W-1:0]          sender_mac,
	input  wire  [arpc_pkg::IP_W-1:0]           target_ip,
	output logic                                hit,
	output logic [arpc_pkg::MAC_W-1:0]          found_mac,
	output logic                                send_reply,
	output logic [arpc_pkg::IP_W-1:0]           reply_ip,
	output logic [arpc_pkg::MAC_W-1:0]          reply_mac,
	output logic                                learned
);
	import arpc_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	// configuration
	logic [AGE_W-1:0] max_age_q;
	logic [IP_W-1:0]  local_ip_q, mask_q;
	logic [MAC_W-1:0] local_mac_q;

	// item
	logic [OP_W-1:0]  op_q;
	logic [IP_W-1:0]  sip_q, tip_q, key_q;
	logic [MAC_W-1:0] smac_q;

	// table
	logic [IP_W-1:0]  addr_mem  [ENTRIES];
	logic [MAC_W-1:0] hw_mem    [ENTRIES];
	logic [AGE_W-1:0] stamp_mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [AGE_W-1:0] now_q;

	// scan
	logic [CW-1:0]    cnt_q;
	logic             rd_vld_s1;
	logic [IW-1:0]    idx_s1;
	logic [IP_W-1:0]  addr_s1;
	logic [MAC_W-1:0] hw_s1;
	logic [AGE_W-1:0] stamp_s1;

	logic             match_q, free_q;
	logic [IW-1:0]    match_idx_q, free_idx_q, old_idx_q, pick;
	logic [AGE_W-1:0] oldest_q, age;
	logic [MAC_W-1:0] hit_mac_q;

	logic learn_ok, is_tick, is_lookup, req_ok, eval, ent_valid, ent_match;

	assign is_tick   = (op_q == OP_TICK);
	assign is_lookup = (op_q == OP_LOOKUP);
	assign learn_ok  = ((op_q == OP_IP) && sip_q != '0 &&
			((sip_q & mask_q) == (local_ip_q & mask_q))) ||
		((op_q == OP_REPLY) && local_ip_q != '0 && tip_q == local_ip_q && sip_q != '0);
	assign req_ok    = (op_q == OP_REQ) && local_ip_q != '0 && tip_q == local_ip_q;

	assign st.need_scan  = is_tick || learn_ok || (is_lookup && tip_q != '0);
	assign st.need_write = learn_ok;
	assign st.scan_done  = rd_vld_s1 && (idx_s1 == IW'(ENTRIES - 1));

	assign eval      = cmd.scan && rd_vld_s1;
	assign ent_valid = valid_q[idx_s1];
	assign ent_match = ent_valid && (addr_s1 == key_q);
	assign age       = now_q - stamp_s1;
	assign pick      = match_q ? match_idx_q : (free_q ? free_idx_q : old_idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q   <= MAX_AGE_RST;
			local_ip_q  <= '0;
			mask_q      <= '0;
			local_mac_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_AGE:   max_age_q   <= cfg_data[AGE_W-1:0];
				REG_LOCAL_IP:  local_ip_q  <= cfg_data[IP_W-1:0];
				REG_MASK:      mask_q      <= cfg_data[IP_W-1:0];
				REG_LOCAL_MAC: local_mac_q <= cfg_data[MAC_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			now_q     <= '0;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q     <= '0;
				rd_vld_s1 <= 1'b0;
				if (op == OP_TICK)
					now_q <= now_q + 1'b1;
			end else if (cmd.scan) begin
				if (cnt_q < CW'(ENTRIES)) begin
					cnt_q     <= cnt_q + 1'b1;
					rd_vld_s1 <= 1'b1;
				end else begin
					rd_vld_s1 <= 1'b0;
				end
			end
			// age out on tick
			if (eval && is_tick && ent_valid && age >= max_age_q)
				valid_q[idx_s1] <= 1'b0;
			if (cmd.write)
				valid_q[pick] <= 1'b1;
		end
	end

	// item capture, scan trackers, table read and write, result load
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op;
			sip_q  <= sender_ip;
			smac_q <= sender_mac;
			tip_q  <= target_ip;
			key_q  <= (op == OP_LOOKUP) ? target_ip : sender_ip;
			match_q     <= 1'b0;
			free_q      <= 1'b0;
			match_idx_q <= '0;
			free_idx_q  <= '0;
			old_idx_q   <= '0;
			oldest_q    <= '0;
			hit_mac_q   <= '0;
		end else if (eval) begin
			if (ent_match && !match_q) begin
				match_q     <= 1'b1;
				match_idx_q <= idx_s1;
				hit_mac_q   <= hw_s1;
			end
			if (!ent_valid && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_s1;
			end
			if (ent_valid && age > oldest_q) begin
				oldest_q  <= age;
				old_idx_q <= idx_s1;
			end
		end
		if (cmd.scan && cnt_q < CW'(ENTRIES)) begin
			idx_s1   <= cnt_q[IW-1:0];
			addr_s1  <= addr_mem[cnt_q[IW-1:0]];
			hw_s1    <= hw_mem[cnt_q[IW-1:0]];
			stamp_s1 <= stamp_mem[cnt_q[IW-1:0]];
		end
		if (cmd.write) begin
			addr_mem[pick]  <= sip_q;
			hw_mem[pick]    <= smac_q;
			stamp_mem[pick] <= now_q;
		end
		if (cmd.out_load) begin
			hit        <= is_lookup && match_q;
			found_mac  <= (is_lookup && match_q) ? hit_mac_q : '0;
			send_reply <= req_ok;
			reply_ip   <= req_ok ? sip_q : '0;
			reply_mac  <= req_ok ? smac_q : '0;
			learned    <= learn_ok;
		end
	end

	// local_mac is held but not driven out of this block
	logic unused_mac;
	assign unused_mac = ^local_mac_q;
endmodule
`default_nettype wire

FILE: hdl/arp_cache_with_aging.sv
// ARP cache with aging: IPv4-to-MAC table of ENTRIES slots.
// Input channel (in_valid/in_stall) carries op, sender_ip, sender_mac,
// target_ip; op selects tick, IP packet seen, ARP request, ARP reply or lookup.
// Output channel (out_valid/out_stall) returns exactly one result per item:
// hit/found_mac for lookups, send_reply/reply_ip/reply_mac for requests to
// the local address, learned when an entry was refreshed or written.
// Configuration: cfg_we writes cfg_data to register cfg_index
// (0 max_age, 1 local_ip, 2 subnet_mask, 3 local_mac); write only while idle.
// Timing: one item at a time. Ticks, learning and lookups with nonzero
// target_ip scan the table one entry per cycle through the registered
// memory read port, and learning adds a write after the scan; requests
// and unused ops skip the scan. The next item can be taken in the cycle
// after the previous result is loaded.
// The result register lets the next item be taken while a result waits;
// a stalled result holds, and an item finishing behind it waits for it.
// Reset clears all valid bits, the tick counter and the handshake state;
// registers return to max_age 120, all others zero.
`default_nettype none
module arp_cache_with_aging #(
	parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire  [arpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [arpc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire  [arpc_pkg::OP_W-1:0]       op,
	input  wire  [arpc_pkg::IP_W-1:0]       sender_ip,
	input  wire  [arpc_pkg::MAC_W-1:0]      sender_mac,
	input  wire  [arpc_pkg::IP_W-1:0]       target_ip,
	output logic                            out_valid,
	input  wire                             out_stall,
	output logic                            hit,
	output logic [arpc_pkg::MAC_W-1:0]      found_mac,
	output logic                            send_reply,
	output logic [arpc_pkg::IP_W-1:0]       reply_ip,
	output logic [arpc_pkg::MAC_W-1:0]      reply_mac,
	output logic                            learned
);
	import arpc_pkg::*;

	arpc_cmd_t    cmd;
	arpc_status_t st;

	// sequencer: accept, scan, write, hand the result over
	arpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	// table, registers and result register
	arpc_dp #(.ENTRIES(ENTRIES)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.op         (op),
		.sender_ip  (sender_ip),
		.sender_mac (sender_mac),
		.target_ip  (target_ip),
		.hit        (hit),
		.found_mac  (found_mac),
		.send_reply (send_reply),
		.reply_ip   (reply_ip),
		.reply_mac  (reply_mac),
		.learned    (learned)
	);
endmodule
`default_nettype wire

FILE: hdl/arpc_checker.sv
`default_nettype none
module arpc_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          in_valid,
	input wire                          in_stall,
	input wire                          out_valid,
	input wire                          out_stall,
	input wire                          hit,
	input wire [arpc_pkg::MAC_W-1:0]    found_mac,
	input wire                          send_reply,
	input wire                          learned
);
	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found_mac))
		else $error("stalled result changed");

	// one item kind sets one group of result fields
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && send_reply) && !(hit && learned) && !(send_reply && learned))
		else $error("result fields of two item kinds set");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> found_mac == '0)
		else $error("found_mac nonzero without hit");

	// the block is busy right after a transfer in
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");
endmodule

bind arp_cache_with_aging arpc_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.hit        (hit),
	.found_mac  (found_mac),
	.send_reply (send_reply),
	.learned    (learned)
);
`default_nettype wire
